// ===== hw/rtl/upd_pkg.sv =====
// Shared types, constants and a helper function for the URL percent/UTF-8 decoder.
package upd_pkg;

   // Characters with a special meaning outside an escape
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   // Queue between the escape front end and the UTF-8 back end
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam int CP_W = 31;

   // Escape tracking in the front end
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HIGH = 2'd1,
      PH_LOW  = 2'd2
   } phase_type;

   // One queue entry: an optional decoded byte plus a state clear marker
   typedef struct packed {
      logic       clear;
      logic       has_byte;
      logic [7:0] data_byte;
   } upd_entry_type;

   // Hex nibble of a character; non-hex characters still yield some nibble
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] lc;
      logic [7:0] sum;
      begin
         lc  = c;
         sum = 8'h00;
         if (c >= 8'h30 && c <= 8'h39) begin
            sum = c - 8'h30;
         end else begin
            if (c >= 8'h41 && c <= 8'h5A) begin
               lc = c + 8'h20;
            end
            sum = lc + 8'h09;
         end
         return sum[3:0];
      end
   endfunction

endpackage

// ===== hw/rtl/url_percent_utf8_decoder.sv =====
// Top level of the URL percent decoder with UTF-8 code point assembly.
//
// Request channel (req_valid/req_ready): one URL character per request in
// req_in_byte; req_start_of_string clears escape and UTF-8 state first.
// Response channel (rsp_valid/rsp_ready): one 31-bit rsp_code_point for each
// ASCII byte or each completed UTF-8 sequence; '%' and nibble characters,
// lead bytes, stray continuations and 0xFE/0xFF produce no response.
// A response passes through a queue slot and then the response register
// after the request that completes it is accepted, behind earlier work.
// Throughput: one request per cycle while the queue has space; the escape front
// end and the UTF-8 back end each process one entry per cycle, joined by a 4-entry queue.
// Reset (synchronous, active high) clears escape state, pending UTF-8 state,
// the queue and the response valid flag.
// When the receiver stalls, the response is held in its register, the back
// end stops popping, and requests are still accepted until the queue fills;
// req_ready then drops until space frees up.
module url_percent_utf8_decoder
   import upd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_in_byte,
   input  logic             req_start_of_string,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [CP_W-1:0]  rsp_code_point
);

   logic          push;
   upd_entry_type push_entry;
   logic          queue_full;
   logic          pop;
   logic          not_empty;
   upd_entry_type head_entry;

   upd_front u_front (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_in_byte         (req_in_byte),
      .req_start_of_string (req_start_of_string),
      .push                (push),
      .push_entry          (push_entry),
      .queue_full          (queue_full)
   );

   upd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .not_empty  (not_empty),
      .head_entry (head_entry)
   );

   upd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .entry_valid    (not_empty),
      .entry          (head_entry),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_code_point (rsp_code_point)
   );

endmodule

// ===== hw/rtl/upd_front.sv =====
// Front end: takes requests, resolves '%' escapes and '+', pushes bytes and start markers to the queue.
module upd_front
   import upd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [7:0]    req_in_byte,
   input  logic          req_start_of_string,
   output logic          push,
   output upd_entry_type push_entry,
   input  logic          queue_full
);

   phase_type  phase_ff, phase_in;
   logic [3:0] high_nibble_ff, high_nibble_in;
   logic       accept;
   phase_type  phase_cur;
   logic       has_byte;
   logic [7:0] data_byte;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Escape decode for the current character
   always_comb begin
      phase_cur      = req_start_of_string ? PH_IDLE : phase_ff;
      phase_in       = phase_ff;
      high_nibble_in = high_nibble_ff;
      has_byte       = 1'b0;
      data_byte      = req_in_byte;
      unique case (phase_cur)
         PH_HIGH: begin
            high_nibble_in = hex_nibble(req_in_byte);
            phase_in       = PH_LOW;
         end
         PH_LOW: begin
            data_byte = {high_nibble_ff, hex_nibble(req_in_byte)};
            has_byte  = 1'b1;
            phase_in  = PH_IDLE;
         end
         PH_IDLE: begin
            priority if (req_in_byte == CHAR_PERCENT) begin
               phase_in = PH_HIGH;
            end else if (req_in_byte == CHAR_PLUS) begin
               data_byte = CHAR_SPACE;
               has_byte  = 1'b1;
               phase_in  = PH_IDLE;
            end else begin
               has_byte = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // A start flag must reach the back end even when no byte comes out
   assign push                 = accept && (has_byte || req_start_of_string);
   assign push_entry.clear     = req_start_of_string;
   assign push_entry.has_byte  = has_byte;
   assign push_entry.data_byte = data_byte;

   // Escape state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         high_nibble_ff <= 4'h0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         high_nibble_ff <= high_nibble_in;
      end
   end

endmodule

// ===== hw/rtl/upd_queue.sv =====
// Small FIFO that decouples the escape front end from the UTF-8 back end.
module upd_queue
   import upd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  upd_entry_type push_entry,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output upd_entry_type head_entry
);

   upd_entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]       count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty  = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Occupancy
   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // Pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && full) |-> pop)
      else $error("push into full queue");
`endif

endmodule

// ===== hw/rtl/upd_back.sv =====
// Back end: UTF-8 assembly of queued bytes and the registered result stage.
module upd_back
   import upd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             entry_valid,
   input  upd_entry_type    entry,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [CP_W-1:0]  rsp_code_point
);

   logic [CP_W-1:0] acc_ff, acc_in;
   logic [2:0]      pend_ff, pend_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [CP_W-1:0] rsp_cp_ff, rsp_cp_in;
   logic [CP_W-1:0] acc_cur;
   logic [2:0]      pend_cur;
   logic            emit;
   logic [CP_W-1:0] emit_cp;
   logic [7:0]      b;

   // Pop whenever the result register is free or being drained
   assign pop = entry_valid && (!rsp_valid_ff || rsp_ready);
   assign b   = entry.data_byte;

   // UTF-8 assembly step
   always_comb begin
      acc_cur  = entry.clear ? '0 : acc_ff;
      pend_cur = entry.clear ? 3'd0 : pend_ff;
      acc_in   = acc_cur;
      pend_in  = pend_cur;
      emit     = 1'b0;
      emit_cp  = {{(CP_W-8){1'b0}}, b};
      if (entry.has_byte) begin
         priority if (b[7:6] == 2'b10) begin
            if (pend_cur != 3'd0) begin
               acc_in  = {acc_cur[CP_W-7:0], b[5:0]};
               pend_in = pend_cur - 3'd1;
               emit    = (pend_cur == 3'd1);
               emit_cp = acc_in;
            end
         end else if (b[7] == 1'b0) begin
            emit = 1'b1;
         end else if (b[7:5] == 3'b110) begin
            acc_in  = {{(CP_W-5){1'b0}}, b[4:0]};
            pend_in = 3'd1;
         end else if (b[7:4] == 4'b1110) begin
            acc_in  = {{(CP_W-4){1'b0}}, b[3:0]};
            pend_in = 3'd2;
         end else if (b[7:3] == 5'b11110) begin
            acc_in  = {{(CP_W-3){1'b0}}, b[2:0]};
            pend_in = 3'd3;
         end else if (b[7:2] == 6'b111110) begin
            acc_in  = {{(CP_W-2){1'b0}}, b[1:0]};
            pend_in = 3'd4;
         end else if (b[7:1] == 7'b1111110) begin
            acc_in  = {{(CP_W-1){1'b0}}, b[0]};
            pend_in = 3'd5;
         end else begin
            // 0xFE and 0xFF: ignored
            acc_in  = acc_cur;
            pend_in = pend_cur;
         end
      end
   end

   // Result register next state
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_cp_in    = rsp_cp_ff;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
         rsp_cp_in    = emit_cp;
      end
   end

   // Assembler state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         pend_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            acc_ff  <= acc_in;
            pend_ff <= pend_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_cp_ff <= rsp_cp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = rsp_cp_ff;

`ifndef SYNTH
   a_pend_range: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 3'd5)
      else $error("pending count out of range");
   a_reset_clean: assert property (@(posedge clock)
      $past(reset) |-> (pend_ff == 3'd0 && !rsp_valid_ff))
      else $error("assembler not clear after reset");
   a_no_pop_stalled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !pop)
      else $error("queue popped while result stalled");
`endif

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the URL percent decoder with UTF-8 code point assembly.
module tb_top
   import upd_pkg::*;
;

   // Tracks expected code points by decoding each accepted request in software
   class code_point_scoreboard;
      phase_type       esc_phase;
      logic [3:0]      esc_high;
      logic [CP_W-1:0] cp_accum;
      logic [2:0]      cont_left;
      logic [CP_W-1:0] cp_expected[$];
      int              errors;
      int              checked;

      function new();
         esc_phase = PH_IDLE;
         esc_high  = 4'h0;
         cp_accum  = '0;
         cont_left = 3'd0;
         errors    = 0;
         checked   = 0;
      endfunction

      // Nibble value of a character; non-hex characters still map somewhere
      function logic [3:0] char_nibble(input logic [7:0] c);
         logic [7:0] folded;
         if (c >= 8'h30 && c <= 8'h39) begin
            return c[3:0];
         end
         folded = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
         folded = folded + 8'h09;
         return folded[3:0];
      endfunction

      // UTF-8 assembly of one decoded byte
      function void assemble_byte(input logic [7:0] b);
         if (b[7:6] == 2'b10) begin
            // continuation: ignored when nothing is pending
            if (cont_left != 3'd0) begin
               cp_accum  = {cp_accum[CP_W-7:0], b[5:0]};
               cont_left = cont_left - 3'd1;
               if (cont_left == 3'd0) cp_expected.push_back(cp_accum);
            end
         end else if (!b[7]) begin
            // ASCII leaves any pending sequence alone
            cp_expected.push_back({23'd0, b});
         end else begin
            casez (b)
               8'b110?????: begin cp_accum = {26'd0, b[4:0]}; cont_left = 3'd1; end
               8'b1110????: begin cp_accum = {27'd0, b[3:0]}; cont_left = 3'd2; end
               8'b11110???: begin cp_accum = {28'd0, b[2:0]}; cont_left = 3'd3; end
               8'b111110??: begin cp_accum = {29'd0, b[1:0]}; cont_left = 3'd4; end
               8'b1111110?: begin cp_accum = {30'd0, b[0]};   cont_left = 3'd5; end
               default: ;  // 0xFE and 0xFF are dropped
            endcase
         end
      endfunction

      // Called for every accepted request
      function void note_request(input logic [7:0] c, input logic sos);
         if (sos) begin
            esc_phase = PH_IDLE;
            esc_high  = 4'h0;
            cp_accum  = '0;
            cont_left = 3'd0;
         end
         case (esc_phase)
            PH_HIGH: begin
               esc_high  = char_nibble(c);
               esc_phase = PH_LOW;
            end
            PH_LOW: begin
               esc_phase = PH_IDLE;
               assemble_byte({esc_high, char_nibble(c)});
            end
            default: begin
               if (c == CHAR_PERCENT) esc_phase = PH_HIGH;
               else if (c == CHAR_PLUS) assemble_byte(CHAR_SPACE);
               else assemble_byte(c);
            end
         endcase
      endfunction

      // Called for every accepted response
      function void check_response(input logic [CP_W-1:0] cp);
         logic [CP_W-1:0] want;
         checked++;
         if (cp_expected.size() == 0) begin
            $error("unexpected response: code_point actual %0h", cp);
            errors++;
            return;
         end
         want = cp_expected.pop_front();
         if (cp !== want) begin
            $error("code_point: expected %0h, actual %0h", want, cp);
            errors++;
         end
      endfunction

      function int outstanding();
         return cp_expected.size();
      endfunction

      function void drain_check();
         if (cp_expected.size() != 0) begin
            $error("%0d code points never arrived", cp_expected.size());
            errors++;
         end
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   logic [7:0]      req_in_byte = 8'h00;
   logic            req_start_of_string = 1'b0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic [CP_W-1:0] rsp_code_point;

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   int unsigned requests_sent = 0;
   int unsigned drain_cycles;

   code_point_scoreboard cp_board = new();

   url_percent_utf8_decoder i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_in_byte         (req_in_byte),
      .req_start_of_string (req_start_of_string),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_code_point      (rsp_code_point)
   );

   always #5 clock = ~clock;

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
   end

   // Handshake monitor: requests feed the predictor, responses get checked
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) cp_board.note_request(req_in_byte, req_start_of_string);
         if (rsp_valid && rsp_ready) cp_board.check_response(rsp_code_point);
      end
   end

   // One request, with random idle cycles ahead of it
   task automatic push_char(input logic [7:0] c, input logic sos);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_in_byte         <= c;
      req_start_of_string <= sos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      requests_sent++;
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + n;
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10;
   endfunction

   // A byte sent raw, as '+' for space, or percent-escaped
   task automatic push_encoded(input logic [7:0] b, input logic sos);
      if (b == CHAR_PERCENT || b == CHAR_PLUS || $urandom_range(0, 2) == 0) begin
         push_char(CHAR_PERCENT, sos);
         push_char(hex_char(b[7:4]), 1'b0);
         push_char(hex_char(b[3:0]), 1'b0);
      end else if (b == CHAR_SPACE && $urandom_range(0, 1) == 1) begin
         push_char(CHAR_PLUS, sos);
      end else begin
         push_char(b, sos);
      end
   endtask

   // One UTF-8 sequence of 1 to 6 bytes, optionally truncated or interrupted
   task automatic push_utf8_sequence(input bit broken);
      int unsigned nbytes;
      int unsigned bits;
      int unsigned cp;
      int unsigned cut;
      logic [7:0]  seq[$];
      logic        sos_first;
      nbytes = $urandom_range(1, 6);
      if (nbytes == 1) begin
         cp = $urandom_range(0, 127);
         seq.push_back(cp[7:0]);
      end else begin
         bits = 7 - nbytes + 6 * (nbytes - 1);
         cp   = $urandom & ((32'd1 << bits) - 32'd1);
         seq.push_back(8'((8'hFF << (8 - nbytes)) | (cp >> (6 * (nbytes - 1)))));
         for (int i = nbytes - 2; i >= 0; i--) begin
            seq.push_back(8'(8'h80 | ((cp >> (6 * i)) & 32'h3F)));
         end
      end
      if (broken) begin
         if ($urandom_range(0, 1) == 0) begin
            cut = $urandom_range(1, seq.size());
            repeat (cut) seq.delete(seq.size() - 1);
         end else begin
            seq.insert($urandom_range(0, seq.size()), 8'($urandom));
         end
      end
      sos_first = ($urandom_range(0, 9) == 0);
      foreach (seq[i]) push_encoded(seq[i], (i == 0) && sos_first);
   endtask

   // Sender holds off until every expected code point is back
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (cp_board.outstanding() != 0) @(posedge clock);
   endtask

   task automatic run_random(input int unsigned n_requests);
      int unsigned target;
      int unsigned pick;
      target = requests_sent + n_requests;
      while (requests_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 75) push_utf8_sequence(1'b0);
         else if (pick < 87) push_utf8_sequence(1'b1);
         else if (pick < 90) push_char(CHAR_PERCENT, 1'b0);
         else push_char(8'($urandom), $urandom_range(0, 19) == 0);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, '+', escapes, continuations and invalid bytes
      push_char(8'h41, 1'b1);
      push_char(8'h00, 1'b0);
      push_char(8'h7F, 1'b0);
      push_char(CHAR_PLUS, 1'b0);
      push_char(CHAR_PERCENT, 1'b0);
      push_char(8'h63, 1'b0);            // lowercase hex
      push_char(CHAR_PERCENT, 1'b0);
      push_char(8'h41, 1'b0);            // uppercase letter, passed on as ASCII
      push_char(8'h39, 1'b0);            // digit, passed on as ASCII; the 0xCE lead from the escape stays pending
      push_char(8'h80, 1'b0);            // continuation that completes the 0xCE sequence
      push_char(8'hFE, 1'b0);
      push_char(8'hFF, 1'b0);
      // lead replaced by a new lead, ASCII emitted mid-sequence
      push_char(8'hC3, 1'b0);
      push_char(8'hE2, 1'b0);
      push_char(8'h78, 1'b0);
      push_char(8'h82, 1'b0);
      push_char(8'hAC, 1'b0);
      // largest 6-byte code point
      push_char(8'hFD, 1'b0);
      repeat (5) push_char(8'hBF, 1'b0);
      // '%', '+' and non-hex characters read as nibbles
      push_char(CHAR_PERCENT, 1'b0);
      push_char(CHAR_PLUS, 1'b0);
      push_char(8'h67, 1'b0);
      // start flag in the middle of an escape
      push_char(CHAR_PERCENT, 1'b0);
      push_char(8'h34, 1'b0);
      push_char(8'h42, 1'b1);

      // Random phases with different idle and stall mixes
      run_random(480);
      pause_until_drained();
      sender_idle_pct = 88;
      run_random(480);
      sender_idle_pct    = 0;
      receiver_stall_pct = 88;
      run_random(480);
      pause_until_drained();
      sender_idle_pct    = 32;
      receiver_stall_pct = 32;
      run_random(480);
      req_valid <= 1'b0;

      // Drain, then give any spurious response time to show up
      drain_cycles = 0;
      while (cp_board.outstanding() != 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (20) @(posedge clock);
      cp_board.drain_check();

      $display("Sent %0d requests and checked %0d code points: escapes, '+', 1 to 6 byte",
               requests_sent, cp_board.checked);
      $display("sequences, broken sequences and noise under four idle and stall mixes.");
      if (cp_board.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/upd_pkg.sv
hw/rtl/upd_front.sv
hw/rtl/upd_queue.sv
hw/rtl/upd_back.sv
hw/rtl/url_percent_utf8_decoder.sv
tb/tb_top.sv
